// ----- hw/rtl/fla_pkg.sv -----
// Shared types and constants for the fixed-block free-list allocator.
package fla_pkg;

  localparam int DEF_NUM_BLOCKS  = 16;
  localparam int DEF_BLOCK_BYTES = 32;

  // Field widths of the request and result transfers
  localparam int OFF_W      = 10;
  localparam int ADDR_OUT_W = 9;
  localparam int CNT_OUT_W  = 5;

  // Widest block index the parameter range allows (256 blocks)
  localparam int MAX_IDX_W = 8;

  // Depth of the command queue between front and back
  localparam int Q_DEPTH = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic             op;
    logic [OFF_W-1:0] byte_offset;
  } fla_in_t;

  typedef struct packed {
    logic                  ok;
    logic [ADDR_OUT_W-1:0] block_address;
    logic [CNT_OUT_W-1:0]  blocks_in_use;
  } fla_out_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic                 op;
    logic                 bad;   // free offset outside the pool or off a block start
    logic [MAX_IDX_W-1:0] blk;   // block index named by a free
  } fla_cmd_t;

endpackage

// ----- hw/rtl/fla_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/fla_front.sv -----
// Front end: accept requests, decode the free offset into a block index, queue commands.
module fla_front import fla_pkg::*; #(
  parameter int NUM_BLOCKS  = DEF_NUM_BLOCKS,
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
  input  logic     in_valid,
  output logic     in_stall,
  input  fla_in_t  in_data,
  output logic     q_push,
  output fla_cmd_t q_push_data,
  input  logic     q_full
);

  // Exact divide of a 10-bit offset by a constant: multiply by a rounded-up
  // reciprocal with enough guard bits; the low product bits fall below the
  // reciprocal exactly when the remainder is zero.
  localparam int SH     = 11 + $clog2(BLOCK_BYTES);
  localparam int RECIP  = (1 << SH) / BLOCK_BYTES + 1;
  localparam int PROD_W = SH + OFF_W;

  logic [PROD_W-1:0] prod;
  logic [OFF_W-1:0]  quot;
  logic [SH-1:0]     frac;
  logic              aligned;
  logic              in_pool;

  assign prod    = PROD_W'(in_data.byte_offset) * PROD_W'(RECIP);
  assign quot    = prod[PROD_W-1:SH];
  assign frac    = prod[SH-1:0];
  assign aligned = frac < SH'(RECIP);
  assign in_pool = 32'(quot) < 32'(NUM_BLOCKS);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_push_data.op  = in_data.op;
    q_push_data.bad = !(aligned && in_pool);
    q_push_data.blk = MAX_IDX_W'(quot);
  end

endmodule

// ----- hw/rtl/fla_queue.sv -----
// Short command queue that decouples the front end from the back end.
module fla_queue import fla_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  fla_cmd_t push_data,
  output logic     full,
  input  logic     pop,
  output fla_cmd_t pop_data,
  output logic     empty
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  fla_cmd_t         entry_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = count_r == CNT_W'(Q_DEPTH);
  assign empty    = count_r == '0;
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/fla_back.sv -----
// Back end: walk the free list in the link/owner memory and produce results.
module fla_back import fla_pkg::*; #(
  parameter int NUM_BLOCKS  = DEF_NUM_BLOCKS,
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  fla_cmd_t q_data,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_stall,
  output fla_out_t out_data
);

  localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int LINK_W = $clog2(NUM_BLOCKS + 1);
  localparam int VLD_N  = 1 << IDX_W;
  localparam int ENT_W  = LINK_W + 1;
  localparam int ADDR_W = IDX_W + $clog2(BLOCK_BYTES) + 1;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_BLOCKS);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } fla_state_t;

  fla_state_t        state_r, state_nxt;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [LINK_W-1:0] cnt_r, cnt_nxt;
  logic [VLD_N-1:0]  vld_r, vld_nxt;
  logic              cur_op_r, cur_bad_r, vld_q_r;
  logic [IDX_W-1:0]  cur_idx_r;
  logic              out_valid_r, out_valid_nxt;
  fla_out_t          out_data_r, out_data_nxt;

  logic              re, we, done, ok, is_alloc, ent_owned;
  logic [IDX_W-1:0]  raddr;
  logic [ENT_W-1:0]  rdata, wdata;
  logic [LINK_W-1:0] ent_link;
  logic [ADDR_W-1:0] addr_prod;

  fla_ram #(
    .WIDTH(ENT_W),
    .DEPTH(NUM_BLOCKS)
  ) u_link_ram (
    .clk  (clk),
    .we   (we),
    .waddr(cur_idx_r),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign re    = (state_r == S_IDLE) && !q_empty;
  assign q_pop = re;
  assign raddr = (q_data.op == OP_ALLOC) ? head_r[IDX_W-1:0] : q_data.blk[IDX_W-1:0];

  // An entry never written reads as its reset value: not owned, links to the next block
  assign ent_owned = vld_q_r ? rdata[ENT_W-1]    : 1'b0;
  assign ent_link  = vld_q_r ? rdata[LINK_W-1:0] : LINK_W'(cur_idx_r) + LINK_W'(1);

  assign is_alloc  = cur_op_r == OP_ALLOC;
  assign ok        = is_alloc ? (head_r != NULL_LINK) : (!cur_bad_r && ent_owned);
  assign done      = (state_r == S_EXEC) && (!out_valid_r || !out_stall);
  assign we        = done && ok;
  assign wdata     = is_alloc ? {1'b1, ent_link} : {1'b0, head_r};
  assign addr_prod = ADDR_W'(cur_idx_r) * ADDR_W'(BLOCK_BYTES);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (re) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (done) begin
          if (ok) begin
            head_nxt          = is_alloc ? ent_link : LINK_W'(cur_idx_r);
            cnt_nxt           = is_alloc ? cnt_r + LINK_W'(1) : cnt_r - LINK_W'(1);
            vld_nxt[cur_idx_r] = 1'b1;
          end
          out_valid_nxt              = 1'b1;
          out_data_nxt.ok            = ok;
          out_data_nxt.block_address = (is_alloc && ok) ? ADDR_OUT_W'(addr_prod) : '0;
          out_data_nxt.blocks_in_use = CNT_OUT_W'(cnt_nxt);
          state_nxt                  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (re) begin
      cur_op_r  <= q_data.op;
      cur_bad_r <= q_data.bad;
      cur_idx_r <= raddr;
      vld_q_r   <= vld_r[raddr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LINK_W'(NUM_BLOCKS))
    else $error("in-use count exceeds pool size");

  a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == NULL_LINK) == (cnt_r == LINK_W'(NUM_BLOCKS)))
    else $error("free list head disagrees with in-use count");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result appeared outside the execute step");

  a_mem_write_exec: assert property (@(posedge clk) disable iff (!rst_n)
    we |=> out_valid_r && out_data_r.ok)
    else $error("memory update without a successful result");

endmodule

// ----- hw/rtl/fixed_block_free_list_allocator_unit.sv -----
// Top level of the fixed-block free-list allocator.
// Pool allocator for NUM_BLOCKS equal blocks of BLOCK_BYTES bytes, kept on a LIFO
// free list that after reset runs block 0, 1, 2 and so on. An allocate request
// (op = 0) pops the head block and returns its byte offset; a free request
// (op = 1) pushes back the block at byte_offset if the offset is inside the pool,
// on a block start and names an owned block. A failed request changes nothing and
// returns ok = 0 with a zero address. Every result carries the in-use count after
// the request. Each request transfer yields exactly one result transfer, in order.
// Timing: the front end decodes the offset combinationally and pushes the command
// into a two-entry queue at the request transfer. The idle back end then pops it
// while reading the link/owner memory at the head or the named block; in its
// execute state, unless a held result is stalled, it writes the entry back and
// loads the output register. It pops no new request before that write-back, as
// the registered read and write-back of that single memory allow, and the input
// stalls only once the queue holds two commands. Reset needs no clearing pass:
// per-block valid flops stand in for the memory's reset contents, so requests are
// taken right away.
module fixed_block_free_list_allocator_unit import fla_pkg::*; #(
  parameter int NUM_BLOCKS  = DEF_NUM_BLOCKS,
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  fla_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output fla_out_t out_data
);

  logic     q_push, q_full, q_pop, q_empty;
  fla_cmd_t q_push_data, q_pop_data;

  // Decode and classify; stall only while the queue is full
  fla_front #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_push     (q_push),
    .q_push_data(q_push_data),
    .q_full     (q_full)
  );

  // Hold classified commands while the back end is busy or the output is stalled
  fla_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .empty    (q_empty)
  );

  // Execute against the free list and drive the output register
  fla_back #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_pop_data),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
